/* design/lsi_pkg.sv */
// ----------------------------------------------------------------------------
// lsi_pkg
// Shared types and constants of the light schedule interpolator.
// ----------------------------------------------------------------------------
package lsi_pkg;

  localparam int TIME_W  = 17;
  localparam int LEVEL_W = 7;
  localparam int PACK_W  = 56;
  localparam int CHAN_W  = 3;
  localparam int DUTY_W  = 8;
  localparam int NUM_W   = 32;
  localparam int DEN_W   = 24;

  localparam logic [TIME_W-1:0]  DAY_SECONDS  = 17'd86400;
  localparam logic [LEVEL_W-1:0] FULL_PERCENT = 7'd100;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_COUNT  = 2'd1;
  localparam logic [1:0] REG_MANUAL = 2'd2;

  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [PACK_W-1:0]  pack_t;
  typedef logic [LEVEL_W-1:0] level_t;

  // Pick one 7-bit level out of a packed word and clamp it to 100.
  function automatic level_t level_of(input pack_t packed_lv, input logic [CHAN_W-1:0] ch);
    level_t v;
    v = level_t'(packed_lv >> (7 * int'(ch)));
    return (v > FULL_PERCENT) ? FULL_PERCENT : v;
  endfunction

endpackage

/* design/light_schedule_interpolator_unit.sv */
// ----------------------------------------------------------------------------
// light_schedule_interpolator_unit
// LED brightness engine: a breakpoint table in memory, a segment walk and
// per-channel linear interpolation scaled to an 8-bit duty.
// ----------------------------------------------------------------------------
//  channel   signals                                    direction
//  request   start, busy, kind, time_of_day,            in (busy out)
//            point_index, point_time, point_levels
//  result    strobe, channel, brightness, last          out
//  config    wr_en, wr_index, wr_data                   in
//
//  A load is written at the accepting edge and busy stays low.
//  A schedule tick runs at least one segment-walk step (memory read, compare),
//  then per channel a multiply, a divider load, a wait on the 32-step divider
//  and an emit, for eight channels; busy stays high for the whole tick.
//  A manual tick skips the walk and runs only once after each manual write.
//  Reset is synchronous; no clearing pass is needed (slots 0 and 1 carry
//  flags). Results appear one per strobe cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module light_schedule_interpolator_unit
  import lsi_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int CHANNELS   = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                kind,
  input  logic [TIME_W-1:0]   time_of_day,
  input  logic [5:0]          point_index,
  input  logic [TIME_W-1:0]   point_time,
  input  logic [PACK_W-1:0]   point_levels,
  output logic                strobe,
  output logic [CHAN_W-1:0]   channel,
  output logic [DUTY_W-1:0]   brightness,
  output logic                last,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [PACK_W-1:0]   wr_data
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int PW = $clog2(MAX_POINTS + 1);
  localparam int CW = (PW > 7) ? PW : 7;
  localparam int SW = $clog2(MAX_POINTS + 2);
  localparam int PRODW = LEVEL_W + TIME_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIVL = 3'd4;
  localparam logic [2:0] S_DIVW = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]        state;
  logic              mode;
  logic [6:0]        pcount;
  pack_t             manual;
  logic              pending;
  logic [IW-1:0]     seg;
  logic [PW-1:0]     pc;
  logic [SW-1:0]     steps;
  time_t             tick_t, t0, t1;
  pack_t             lv0, lv1;
  logic              man;
  logic [CHAN_W-1:0] k;
  logic [PRODW-1:0]  p1, p2;
  time_t             dd;
  logic [DUTY_W-1:0] bright;

  logic              accept;
  logic              load_we;
  time_t             time_a, time_b;
  pack_t             lev_a, lev_b;
  logic [CW-1:0]     pc_wide;
  logic [PW-1:0]     pc_c;
  logic [IW-1:0]     seg_c;
  logic [PW-1:0]     seg_w;
  level_t            lvl_a, lvl_b;
  logic              low_end, high_end;
  time_t             fa, fb;
  logic [PRODW:0]    num;
  logic [NUM_W-1:0]  numer;
  logic [DEN_W-1:0]  denom;
  logic              div_start, div_done;
  logic [NUM_W-1:0]  quot;

  assign accept  = start && !busy;
  assign busy    = (state != S_IDLE);
  assign load_we = accept && kind && (int'(point_index) < MAX_POINTS);

  lsi_store #(.DEPTH(MAX_POINTS), .IW(IW)) u_store (
    .clk     (clk),
    .rst     (rst),
    .we      (load_we),
    .waddr   (IW'(point_index)),
    .wtime   (point_time),
    .wlevels (point_levels),
    .ra      (seg),
    .rb      (seg - 1'b1),
    .time_a  (time_a),
    .time_b  (time_b),
    .lev_a   (lev_a),
    .lev_b   (lev_b)
  );

  lsi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (numer),
    .divisor  (denom),
    .done     (div_done),
    .quotient (quot)
  );

  // Clamp the point count and the segment pointer before the walk.
  always_comb begin
    pc_wide = CW'(pcount);
    if (pc_wide < CW'(2))               pc_c = PW'(2);
    else if (pc_wide > CW'(MAX_POINTS)) pc_c = PW'(MAX_POINTS);
    else                                pc_c = PW'(pc_wide);
    seg_w = PW'(seg);
    if (seg_w < PW'(1))             seg_c = IW'(1);
    else if (seg_w > pc_c - 1'b1)   seg_c = IW'(pc_c - 1'b1);
    else                            seg_c = seg;
  end

  // Interpolation weights: the end cases collapse to a single level over 1.
  // A manual tick never looks at the table, so drop the later level there.
  always_comb begin
    lvl_a    = man ? level_of(manual, k) : level_of(lv0, k);
    lvl_b    = man ? '0 : level_of(lv1, k);
    low_end  = man || (t1 <= t0) || (tick_t <= t0);
    high_end = (tick_t >= t1);
    if (low_end) begin
      fa = time_t'(1);
      fb = '0;
    end else if (high_end) begin
      fa = '0;
      fb = time_t'(1);
    end else begin
      fa = t1 - tick_t;
      fb = tick_t - t0;
    end
    num       = {1'b0, p1} + {1'b0, p2};
    numer     = NUM_W'({num, 8'd0} - {8'd0, num});
    denom     = DEN_W'({dd, 6'd0}) + DEN_W'({dd, 5'd0}) + DEN_W'({dd, 2'd0});
    div_start = (state == S_DIVL);
  end

  // Configuration registers and the manual one-shot flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= 1'b0;
      pcount  <= 7'd2;
      manual  <= '0;
      pending <= 1'b0;
    end else begin
      if (accept && !kind && !mode) pending <= 1'b0;
      if (wr_en) begin
        unique case (wr_index)
          REG_MODE:   mode   <= wr_data[0];
          REG_COUNT:  pcount <= wr_data[6:0];
          REG_MANUAL: begin
            manual  <= wr_data;
            pending <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Sequencer: walk, then per channel multiply, divide, emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seg   <= IW'(1);
      k     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          k <= '0;
          if (accept && !kind) begin
            if (!mode) begin
              if (pending) state <= S_MUL;
            end else begin
              seg   <= seg_c;
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_CMP;
        S_CMP: begin
          priority if (steps == SW'(MAX_POINTS + 1)) begin
            state <= S_MUL;
          end else if (time_a < tick_t && PW'(seg) < pc - 1'b1) begin
            seg   <= seg + 1'b1;
            state <= S_READ;
          end else if (time_a >= tick_t && time_b > tick_t && seg > IW'(1)) begin
            seg   <= seg - 1'b1;
            state <= S_READ;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL:  state <= S_DIVL;
        S_DIVL: state <= S_DIVW;
        S_DIVW: if (div_done) state <= S_EMIT;
        S_EMIT: begin
          if (k == CHAN_W'(CHANNELS - 1)) begin
            state <= S_IDLE;
          end else begin
            k     <= k + 1'b1;
            state <= S_MUL;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      tick_t <= time_of_day;
      man    <= !mode;
      pc     <= pc_c;
      steps  <= '0;
    end
    if (state == S_CMP) begin
      t0  <= time_b;
      t1  <= time_a;
      lv0 <= lev_b;
      lv1 <= lev_a;
      if (state == S_CMP) steps <= steps + 1'b1;
    end
    if (state == S_MUL) begin
      p1 <= PRODW'(lvl_a * fa);
      p2 <= PRODW'(lvl_b * fb);
      dd <= (low_end || high_end) ? time_t'(1) : t1 - t0;
    end
    if (state == S_DIVW && div_done) bright <= quot[DUTY_W-1:0];
  end

  assign strobe     = (state == S_EMIT);
  assign channel    = k;
  assign brightness = bright;
  assign last       = strobe && (k == CHAN_W'(CHANNELS - 1));

endmodule

/* design/lsi_store.sv */
// ----------------------------------------------------------------------------
// lsi_store
// Breakpoint table: time and level memories, one write port and two read
// ports each, with registered reads. Slots 0 and 1 read as their reset
// values until first written.
// ----------------------------------------------------------------------------
module lsi_store
  import lsi_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  time_t         wtime,
  input  pack_t         wlevels,
  input  logic [IW-1:0] ra,
  input  logic [IW-1:0] rb,
  output time_t         time_a,
  output time_t         time_b,
  output pack_t         lev_a,
  output pack_t         lev_b
);

  time_t time_mem [DEPTH];
  pack_t lev_mem  [DEPTH];
  time_t time_ra, time_rb;
  pack_t lev_ra, lev_rb;
  logic  seen0, seen1;
  logic  fresh0_a, fresh1_a, fresh0_b, fresh1_b;

  always_ff @(posedge clk) begin
    if (we) begin
      time_mem[waddr] <= wtime;
      lev_mem[waddr]  <= wlevels;
    end
    time_ra <= time_mem[ra];
    time_rb <= time_mem[rb];
    lev_ra  <= lev_mem[ra];
    lev_rb  <= lev_mem[rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen0    <= 1'b0;
      seen1    <= 1'b0;
      fresh0_a <= 1'b0;
      fresh1_a <= 1'b0;
      fresh0_b <= 1'b0;
      fresh1_b <= 1'b0;
    end else begin
      if (we && waddr == IW'(0)) seen0 <= 1'b1;
      if (we && waddr == IW'(1)) seen1 <= 1'b1;
      fresh0_a <= !seen0 && ra == IW'(0);
      fresh1_a <= !seen1 && ra == IW'(1);
      fresh0_b <= !seen0 && rb == IW'(0);
      fresh1_b <= !seen1 && rb == IW'(1);
    end
  end

  always_comb begin
    time_a = fresh0_a ? '0 : (fresh1_a ? DAY_SECONDS : time_ra);
    time_b = fresh0_b ? '0 : (fresh1_b ? DAY_SECONDS : time_rb);
    lev_a  = (fresh0_a || fresh1_a) ? '0 : lev_ra;
    lev_b  = (fresh0_b || fresh1_b) ? '0 : lev_rb;
  end

endmodule

/* design/lsi_div.sv */
// ----------------------------------------------------------------------------
// lsi_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsi_div
  import lsi_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt;
  logic             run;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;

  always_comb begin
    shifted = {rem, quotient[NUM_W-1]};
    diff    = {1'b0, shifted} - {2'b00, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(NUM_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      den      <= divisor;
      quotient <= dividend;
    end else if (run) begin
      // restore on a negative trial difference
      if (diff[DEN_W+1]) begin
        rem      <= shifted[DEN_W-1:0];
        quotient <= {quotient[NUM_W-2:0], 1'b0};
      end else begin
        rem      <= diff[DEN_W-1:0];
        quotient <= {quotient[NUM_W-2:0], 1'b1};
      end
    end
  end

endmodule

/* design/lsi_checker.sv */
// ----------------------------------------------------------------------------
// lsi_checker
// Port-level checks of the light schedule interpolator, bound to the top.
// ----------------------------------------------------------------------------
module lsi_checker
  import lsi_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              kind,
  input logic              strobe,
  input logic              last
);

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("result strobe while idle");

  a_last_strobe: assert property (@(posedge clk) disable iff (rst)
    last |-> strobe) else $error("last without strobe");

  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind) |=> !busy && !strobe) else $error("load made work");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe) else $error("result after last");

  a_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> !strobe && busy) else $error("channel sequence broke");

endmodule

bind light_schedule_interpolator_unit lsi_checker u_lsi_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .kind    (kind),
  .strobe  (strobe),
  .last    (last)
);

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for light_schedule_interpolator_unit. A scoreboard
// predicts the brightness of each channel from its own copy of the breakpoint
// table, the segment pointer and the registers. Directed and random requests
// drive the block while the scoreboard compares every strobed result.
// ----------------------------------------------------------------------------
module testbench
  import lsi_pkg::*;
();

  class lsi_scoreboard;
    typedef struct {
      logic [CHAN_W-1:0] channel;
      logic [DUTY_W-1:0] brightness;
      logic              last;
    } duty_t;

    logic [TIME_W-1:0] slot_time [64];
    logic [PACK_W-1:0] slot_level [64];
    int unsigned       segment;
    bit                manual_armed;
    bit                schedule_mode;
    int unsigned       count_reg;
    logic [PACK_W-1:0] manual_word;
    duty_t             pending_duty[$];
    int                errors;

    function void reset_state();
      foreach (slot_time[i]) begin
        slot_time[i] = '0;
        slot_level[i] = '0;
      end
      slot_time[1] = 17'd86400;
      segment = 1;
      manual_armed = 0;
      schedule_mode = 0;
      count_reg = 2;
      manual_word = '0;
      pending_duty.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [PACK_W-1:0] data);
      case (idx)
        REG_MODE: begin
          schedule_mode = data[0];
        end
        REG_COUNT: begin
          count_reg = data[6:0];
        end
        REG_MANUAL: begin
          manual_word = data;
          manual_armed = 1;
        end
        default: begin
        end
      endcase
    endfunction

    function int unsigned percent(logic [PACK_W-1:0] word, int ch);
      int unsigned v;
      v = (word >> (7 * ch)) & 7'h7f;
      return (v > 100) ? 100 : v;
    endfunction

    function logic [DUTY_W-1:0] to_duty(longint unsigned num, longint unsigned den);
      return DUTY_W'((num * 255) / (100 * den));
    endfunction

    function void push_duty(int ch, logic [DUTY_W-1:0] b);
      duty_t d;
      d.channel = CHAN_W'(ch);
      d.brightness = b;
      d.last = (ch == 7);
      pending_duty.push_back(d);
    endfunction

    // Note an accepted request and queue the brightness it should produce.
    function void note_request(logic kind, logic [TIME_W-1:0] tod, logic [5:0] idx,
                               logic [TIME_W-1:0] ptime, logic [PACK_W-1:0] plev);
      int unsigned pc, t, t0, t1, a, b, d, u;
      if (kind) begin
        slot_time[idx] = ptime;
        slot_level[idx] = plev;
        return;
      end
      if (!schedule_mode) begin
        if (manual_armed) begin
          for (int ch = 0; ch < 8; ch++) push_duty(ch, to_duty(percent(manual_word, ch), 1));
        end
        manual_armed = 0;
        return;
      end
      t = tod;
      pc = count_reg;
      if (pc < 2) pc = 2;
      if (pc > 64) pc = 64;
      if (segment < 1) segment = 1;
      if (segment > pc - 1) segment = pc - 1;
      // Walk the pointer until the tick falls inside its segment.
      for (int s = 0; s <= 64; s++) begin
        if (slot_time[segment] < t) begin
          if (segment >= pc - 1) break;
          segment++;
        end else if (slot_time[segment-1] > t) begin
          if (segment <= 1) break;
          segment--;
        end else begin
          break;
        end
      end
      t0 = slot_time[segment-1];
      t1 = slot_time[segment];
      for (int ch = 0; ch < 8; ch++) begin
        a = percent(slot_level[segment-1], ch);
        b = percent(slot_level[segment], ch);
        if (t1 <= t0 || t <= t0) begin
          push_duty(ch, to_duty(a, 1));
        end else if (t >= t1) begin
          push_duty(ch, to_duty(b, 1));
        end else begin
          d = t1 - t0;
          u = t - t0;
          push_duty(ch, to_duty(longint'(a) * (d - u) + longint'(b) * u, d));
        end
      end
    endfunction

    function void check_result(logic [CHAN_W-1:0] ch, logic [DUTY_W-1:0] br, logic lst);
      duty_t e;
      if (pending_duty.size() == 0) begin
        $display("%0t: unexpected result ch=%0d brightness=%0d last=%0d", $time, ch, br, lst);
        errors++;
        return;
      end
      e = pending_duty.pop_front();
      if (ch !== e.channel) begin
        $display("%0t: channel expected %0d actual %0d", $time, e.channel, ch);
        errors++;
      end
      if (br !== e.brightness) begin
        $display("%0t: brightness ch%0d expected %0d actual %0d", $time, e.channel,
                 e.brightness, br);
        errors++;
      end
      if (lst !== e.last) begin
        $display("%0t: last ch%0d expected %0d actual %0d", $time, e.channel, e.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              kind;
  logic [TIME_W-1:0] time_of_day;
  logic [5:0]        point_index;
  logic [TIME_W-1:0] point_time;
  logic [PACK_W-1:0] point_levels;
  logic              strobe;
  logic [CHAN_W-1:0] channel;
  logic [DUTY_W-1:0] brightness;
  logic              last;
  logic              wr_en;
  logic [1:0]        wr_index;
  logic [PACK_W-1:0] wr_data;

  lsi_scoreboard sb;
  int            request_count;
  int            gap_pct;
  int            quiet_cycles;

  localparam int WATCHDOG_LIMIT = 6000;

  light_schedule_interpolator_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .time_of_day(time_of_day), .point_index(point_index), .point_time(point_time),
    .point_levels(point_levels), .strobe(strobe), .channel(channel),
    .brightness(brightness), .last(last), .wr_en(wr_en), .wr_index(wr_index),
    .wr_data(wr_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Check every strobed result; the receiver never holds results off.
  always @(posedge clk) begin
    if (!rst && strobe) sb.check_result(channel, brightness, last);
  end

  // Count cycles in which nothing moves; give up when the limit is hit.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("** light_schedule_interpolator_unit: FAILED **");
        $finish;
      end
    end
  end

  // Hold one request until the block takes it, then maybe drop start for a gap.
  task automatic send_request(logic k, logic [TIME_W-1:0] tod, logic [5:0] idx,
                              logic [TIME_W-1:0] pt, logic [PACK_W-1:0] pl);
    start = 1;
    kind = k;
    time_of_day = tod;
    point_index = idx;
    point_time = pt;
    point_levels = pl;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_request(k, tod, idx, pt, pl);
    request_count++;
    @(negedge clk);
    if ($urandom_range(99) < gap_pct) begin
      start = 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task automatic tick(int tod);
    send_request(1'b0, TIME_W'(tod), 6'($urandom), TIME_W'($urandom), PACK_W'({$urandom, $urandom}));
  endtask

  task automatic load_slot(int idx, int pt, logic [PACK_W-1:0] pl);
    send_request(1'b1, TIME_W'($urandom), 6'(idx), TIME_W'(pt), pl);
  endtask

  // Let every expected result drain and the block go quiet before a register write.
  task automatic drain();
    start = 0;
    while (sb.pending_duty.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  // Drop start so no request is taken in the same cycle as the write.
  task automatic write_reg(logic [1:0] idx, logic [PACK_W-1:0] data);
    start = 0;
    wr_en = 1;
    wr_index = idx;
    wr_data = data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    wr_en = 0;
  endtask

  // Random levels, mostly within 0..100 but sometimes above to hit the clamp.
  function automatic logic [PACK_W-1:0] random_levels();
    logic [PACK_W-1:0] w;
    if ($urandom_range(3) == 0) return PACK_W'({$urandom, $urandom});
    for (int ch = 0; ch < 8; ch++) w[7*ch +: 7] = 7'($urandom_range(100));
    return w;
  endfunction

  // Fill slots 0..n-1 with non-decreasing times and random levels.
  task automatic load_schedule(int n);
    int t;
    t = ($urandom_range(1) == 0) ? 0 : $urandom_range(2000);
    for (int i = 0; i < n; i++) begin
      load_slot(i, t, random_levels());
      if ($urandom_range(7) == 0) t = t;
      else t = t + $urandom_range(1, 86400 / n + 1);
      if (t > 86400 || i == n - 2 && $urandom_range(1) == 0) t = 86400;
    end
  endtask

  initial begin
    int n;
    logic [PACK_W-1:0] w;
    sb = new();
    sb.reset_state();
    rst = 1;
    start = 0;
    kind = 0;
    time_of_day = '0;
    point_index = '0;
    point_time = '0;
    point_levels = '0;
    wr_en = 0;
    wr_index = REG_MODE;
    wr_data = '0;
    request_count = 0;
    gap_pct = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Manual mode: nothing until the levels are written, then exactly one burst.
    tick(100);
    for (int ch = 0; ch < 8; ch++) w[7*ch +: 7] = (ch < 2) ? 7'd127 : 7'(ch * 20);
    write_reg(REG_MANUAL, w);
    tick(86399);
    tick(5);
    drain();
    write_reg(REG_MANUAL, {PACK_W{1'b1}});
    tick(0);
    drain();

    // Directed table: zero-width and reversed segments, clamped levels.
    load_slot(0, 0, '0);
    load_slot(1, 1000, {PACK_W{1'b1}});
    load_slot(2, 1000, random_levels());
    load_slot(3, 500, random_levels());
    load_slot(4, 86400, 56'h0AAAAAAAAAAAAA);
    load_slot(63, 86400, 56'h55555555555555);
    drain();
    write_reg(REG_COUNT, 7'd5);
    write_reg(REG_MODE, 1);
    tick(0); tick(86399); tick(1000); tick(500); tick(250);
    tick(999); tick(1500); tick(86399); tick(0); tick(700);
    drain();
    // Out-of-range counts clamp to two points.
    write_reg(REG_COUNT, 7'd0);
    tick(400); tick(86000);
    drain();
    write_reg(REG_COUNT, 7'd1);
    tick(50);
    drain();

    // Random phases; idle profile rotates through none, heavy and light.
    for (int phase = 0; request_count < 260; phase++) begin
      case (phase % 4)
        0: gap_pct = 0;
        1: gap_pct = 71;
        2: gap_pct = 0;
        default: gap_pct = 26;
      endcase
      if (phase % 5 == 4) begin
        write_reg(REG_MODE, 0);
        write_reg(REG_MANUAL, random_levels());
        for (int i = 0; i < 4; i++) tick($urandom_range(86399));
        drain();
        write_reg(REG_MANUAL, PACK_W'({$urandom, $urandom}));
        tick($urandom_range(86399));
        drain();
        continue;
      end
      n = (phase % 7 == 3) ? 64 : $urandom_range(2, 8);
      load_schedule(n);
      drain();
      if (n == 64) write_reg(REG_COUNT, 7'($urandom_range(64, 127)));
      else write_reg(REG_COUNT, 7'(n));
      write_reg(REG_MODE, 1);
      for (int i = 0; i < 20; i++) begin
        if ($urandom_range(99) < 12) load_slot($urandom_range(n - 1), $urandom_range(86400),
                                               random_levels());
        else tick($urandom_range(86399));
      end
      drain();
    end

    start = 0;
    while (sb.pending_duty.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (sb.errors == 0 && sb.pending_duty.size() == 0) begin
      $display("** light_schedule_interpolator_unit: PASSED **");
    end else begin
      $display("** light_schedule_interpolator_unit: FAILED **");
    end
    $finish;
  end
endmodule
